// File: design/sgrg_pkg.sv
`timescale 1ns / 1ps

package sgrg_pkg;

  localparam int CoordW    = 11;
  localparam int ColourW   = 16;
  localparam int ScaleW    = 4;
  localparam int MaskW     = 40;
  localparam int RowCntW   = 6;
  localparam int CfgIdxW   = 2;
  localparam int GlyphCols = 5;
  localparam int GlyphRows = 7;
  localparam int CellPitch = GlyphCols + 1;
  localparam int GlyphW    = 8 * GlyphCols;
  localparam int NumGlyphs = 95;
  localparam int DefMaxScale = 8;

  localparam logic [CoordW-1:0] CoordMax  = '1;
  localparam logic [7:0]        FirstCode = 8'h20;
  localparam logic [7:0]        LastCode  = 8'h7E;
  localparam logic [7:0]        SubstCode = 8'h3F;  // '?'

  localparam logic [ColourW-1:0] FgReset    = 16'hFFFF;
  localparam logic [ColourW-1:0] BgReset    = 16'h0000;
  localparam logic [ScaleW-1:0]  ScaleReset = 4'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FG_COLOUR   = 2'd0,
    CFG_BG_COLOUR   = 2'd1,
    CFG_GLYPH_SCALE = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]        char_code;
    logic              string_start;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] start_y;
  } in_t;

  typedef struct packed {
    logic [CoordW-1:0]  pixel_x;
    logic [CoordW-1:0]  pixel_y;
    logic [MaskW-1:0]   row_mask;
    logic [ColourW-1:0] fg_word;
    logic [ColourW-1:0] bg_word;
    logic               last_row;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;  // take the input item
    logic step;  // emit the next row into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // output register empty or being taken
    logic last;      // next row to emit is the final one
  } dp_status_t;

  // Column 0 in bits [7:0]; bit 0 of each column byte is the top row.
  localparam logic [GlyphW-1:0] GlyphRom [NumGlyphs] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h122A7F2A24,
    40'h6264081323, 40'h5022554936, 40'h0000030500, 40'h0041221C00, 40'h001C224100,
    40'h082A1C2A08, 40'h08083E0808, 40'h0000305000, 40'h0808080808, 40'h0000606000,
    40'h0204081020, 40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
    40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101, 40'h3649494936,
    40'h1E29494906, 40'h0000363600, 40'h0000365600, 40'h0041221408, 40'h1414141414,
    40'h0814224100, 40'h0609510102, 40'h3E41794932, 40'h7E1111117E, 40'h364949497F,
    40'h224141413E, 40'h1C2241417F, 40'h414949497F, 40'h010909097F, 40'h7A4949413E,
    40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F, 40'h404040407F,
    40'h7F0204027F, 40'h7F1008047F, 40'h3E4141413E, 40'h060909097F, 40'h5E2151413E,
    40'h462919097F, 40'h3149494946, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h4345495161, 40'h0041417F00,
    40'h2010080402, 40'h007F414100, 40'h0402010204, 40'h4040404040, 40'h0004020100,
    40'h7854545420, 40'h384444487F, 40'h2044444438, 40'h7F48444438, 40'h1854545438,
    40'h0201097E08, 40'h3C54541408, 40'h780404087F, 40'h00407D4400, 40'h003D444020,
    40'h4428107F00, 40'h00407F4100, 40'h780418047C, 40'h780404087C, 40'h3844444438,
    40'h081414147C, 40'h7C18141408, 40'h080404087C, 40'h2054545448, 40'h2040443F04,
    40'h3C4040403C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h3C5050500C,
    40'h444C546444, 40'h0041360800, 40'h00007F0000, 40'h0008364100, 40'h081C2A0808
  };

  function automatic logic [ColourW-1:0] swap_bytes(input logic [ColourW-1:0] v);
    return {v[7:0], v[15:8]};
  endfunction

  function automatic logic [CoordW-1:0] sat_add(input logic [CoordW-1:0] a,
                                                input logic [RowCntW-1:0] b);
    logic [CoordW:0] s;
    s = {1'b0, a} + {{(CoordW + 1 - RowCntW){1'b0}}, b};
    return s[CoordW] ? CoordMax : s[CoordW-1:0];
  endfunction

endpackage

// File: design/sgrg_ctrl.sv
`timescale 1ns / 1ps

module sgrg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sgrg_pkg::dp_status_t status_i,
  output sgrg_pkg::dp_cmd_t    cmd_o
);
  import sgrg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.step = 1'b1;
          if (status_i.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/sgrg_dpath.sv
`timescale 1ns / 1ps

module sgrg_dpath #(
  parameter int MAX_SCALE = sgrg_pkg::DefMaxScale
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sgrg_pkg::in_t                        in_data_i,
  output sgrg_pkg::out_t                       out_data_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  input  logic                                 cfg_we_i,
  input  logic [sgrg_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [sgrg_pkg::ColourW-1:0]         cfg_data_i,
  input  sgrg_pkg::dp_cmd_t                    cmd_i,
  output sgrg_pkg::dp_status_t                 status_o
);
  import sgrg_pkg::*;

  localparam logic [ScaleW-1:0] MaxScale = ScaleW'(MAX_SCALE);

  logic [ColourW-1:0] fg_q, bg_q;
  logic [ScaleW-1:0]  scale_cfg_q;

  logic [CoordW-1:0]  cursor_x_q, line_y_q;
  logic [CoordW-1:0]  pixel_x_q;
  logic [ScaleW-1:0]  sc_q;
  logic [GlyphW-1:0]  glyph_q;
  logic [RowCntW-1:0] row_q;
  logic [ScaleW-1:0]  sub_q;   // repeat count within one glyph row
  logic [2:0]         grow_q;  // glyph row, 0..6

  logic               out_valid_q;
  out_t               out_q;

  logic [ScaleW-1:0]  sc_eff;
  logic [7:0]         code;
  logic [6:0]         rom_idx;
  logic [CoordW-1:0]  x0, y0;
  logic [RowCntW-1:0] pitch;
  logic [RowCntW-1:0] rows_m1;
  logic [GlyphCols-1:0] row_bits;
  logic [MaskW-1:0]   mask;
  logic               last;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q        <= FgReset;
      bg_q        <= BgReset;
      scale_cfg_q <= ScaleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FG_COLOUR:   fg_q        <= cfg_data_i;
        CFG_BG_COLOUR:   bg_q        <= cfg_data_i;
        CFG_GLYPH_SCALE: scale_cfg_q <= cfg_data_i[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (scale_cfg_q == '0) begin
      sc_eff = ScaleW'(1);
    end else if (scale_cfg_q > MaxScale) begin
      sc_eff = MaxScale;
    end else begin
      sc_eff = scale_cfg_q;
    end
  end

  assign code    = (in_data_i.char_code < FirstCode || in_data_i.char_code > LastCode)
                   ? SubstCode : in_data_i.char_code;
  assign rom_idx = 7'(code - FirstCode);
  assign x0      = in_data_i.string_start ? in_data_i.start_x : cursor_x_q;
  assign y0      = in_data_i.string_start ? in_data_i.start_y : line_y_q;
  assign pitch   = RowCntW'(sc_eff) * RowCntW'(CellPitch);
  assign rows_m1 = RowCntW'(sc_q) * RowCntW'(GlyphRows) - RowCntW'(1);
  assign last    = (row_q == rows_m1);

  always_comb begin
    for (int c = 0; c < GlyphCols; c++) begin
      row_bits[c] = glyph_q[c*8 + int'(grow_q)];
    end
  end

  // replicate each column bit sc_q times; bits at and above 5*scale stay zero
  always_comb begin
    mask = '0;
    for (int s = 1; s <= MAX_SCALE; s++) begin
      if (sc_q == ScaleW'(s)) begin
        for (int c = 0; c < GlyphCols; c++) begin
          for (int k = 0; k < s; k++) begin
            mask[c*s + k] = row_bits[c];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      line_y_q   <= '0;
    end else if (cmd_i.load) begin
      cursor_x_q <= sat_add(x0, pitch);
      line_y_q   <= y0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pixel_x_q <= x0;
      sc_q      <= sc_eff;
      glyph_q   <= GlyphRom[rom_idx];
      row_q     <= '0;
      sub_q     <= '0;
      grow_q    <= '0;
    end else if (cmd_i.step) begin
      row_q <= row_q + RowCntW'(1);
      if (sub_q == sc_q - ScaleW'(1)) begin
        sub_q  <= '0;
        grow_q <= grow_q + 3'd1;
      end else begin
        sub_q <= sub_q + ScaleW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      out_q.pixel_x  <= pixel_x_q;
      out_q.pixel_y  <= sat_add(line_y_q, row_q);
      out_q.row_mask <= mask;
      out_q.fg_word  <= swap_bytes(fg_q);
      out_q.bg_word  <= swap_bytes(bg_q);
      out_q.last_row <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign status_o.last     = last;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;

endmodule

// File: design/scaled_glyph_row_generator_unit.sv
`timescale 1ns / 1ps

// Scaled 5x7 glyph row generator.
// Input channel (in_valid_i/in_ready_o, in_data_i): one character per item.
// Output channel (out_valid_o/out_ready_i, out_data_o): 7*scale row items per
// character, top row first, last_row set on the final one.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): always
// ready; index 0 fg colour, 1 bg colour, 2 scale; other indexes are dropped.
// Write config only while the block is idle.
// Flow: an accepted item is loaded into the working registers, then its first
// row is stepped into the single output register, where out_valid_o rises;
// after that one row per cycle while the receiver keeps ready high. A new
// character is accepted as soon as its predecessor's last row sits in the
// output register.
// A stalled receiver holds the output register; row generation waits.
// Reset clears the cursor and line to 0, colours to white on black and the
// scale to 1; the block is ready right after reset.
module scaled_glyph_row_generator_unit #(
  parameter int MAX_SCALE = sgrg_pkg::DefMaxScale
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  sgrg_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output sgrg_pkg::out_t               out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sgrg_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sgrg_pkg::ColourW-1:0] cfg_data_i
);
  import sgrg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  sgrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sgrg_dpath #(
    .MAX_SCALE (MAX_SCALE)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  // an accepted character is loaded and then its first row stepped onto the output
  a_first_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##2 out_valid_o)
    else $error("no row after accepted item");

  // rows of one character follow back to back
  a_rows_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_data_o.last_row |=> out_valid_o)
    else $error("gap between rows of a character");

  // ready for a new character only once the current one is fully generated
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o |-> out_data_o.last_row)
    else $error("input ready with character rows pending");

endmodule
